/* design/mes_pkg.sv */
// ----------------------------------------------------------------------------
// mes_pkg - shared definitions for the matrix element selector
// Widths, register indexes, selection modes and dimension helpers.
// ----------------------------------------------------------------------------
package mes_pkg;

  localparam int MAX_DIM   = 128;
  localparam int IDX_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 2;
  localparam int DATA_W    = 32;
  // magnitude bits of a positive value
  localparam int U_W       = DATA_W - 1;
  localparam int DIV_W     = 16;
  localparam int SQ_W      = 2 * DIV_W;
  localparam int BIT_CNT_W = $clog2(U_W);

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SELECT_MODE = 2'd2;

  typedef enum logic [1:0] {
    MODE_ALL      = 2'd0,
    MODE_BORDER   = 2'd1,
    MODE_DIAGONAL = 2'd2,
    MODE_PRIME    = 2'd3
  } mode_t;

  // last usable index of a dimension register, count clamped to 1..MAX_DIM
  function automatic logic [IDX_W-1:0] last_index(input logic [CFG_W-1:0] v);
    int n;
    n = int'(v);
    if (n < 1) n = 1;
    if (n > MAX_DIM) n = MAX_DIM;
    return IDX_W'(n - 1);
  endfunction

endpackage

/* design/mes_in_if.sv */
// ----------------------------------------------------------------------------
// mes_in_if - element input channel
// Valid/ready channel carrying one signed matrix element per transaction.
// ----------------------------------------------------------------------------
interface mes_in_if
  import mes_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] element_value;

  modport source (output valid, output element_value, input ready);
  modport sink   (input valid, input element_value, output ready);
endinterface

/* design/mes_out_if.sv */
// ----------------------------------------------------------------------------
// mes_out_if - result output channel
// Valid/ready channel carrying one selection result per transaction.
// ----------------------------------------------------------------------------
interface mes_out_if
  import mes_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] out_value;
  logic                     value_present;
  logic                     row_end;
  logic                     matrix_end;

  modport source (output valid, output out_value, output value_present,
                  output row_end, output matrix_end, input ready);
  modport sink   (input valid, input out_value, input value_present,
                  input row_end, input matrix_end, output ready);
endinterface

/* design/matrix_element_selector_prime.sv */
// ----------------------------------------------------------------------------
// matrix_element_selector_prime - matrix element selector with prime filter
// Tracks row/column of row-major elements and forwards selected ones.
// ----------------------------------------------------------------------------
// Usage:
//   elem carries one matrix element per transaction, row-major order.
//   result carries the selected value (or zero), value_present, row_end and
//   matrix_end. The last element of each row always gives a result; other
//   elements give one only when selected.
//   cfg_we/cfg_index/cfg_data write row_count, col_count and select_mode;
//   write only while no element is in flight.
// Sequencing:
//   one element at a time. All, border and diagonal modes go straight to the
//   emit step. Prime mode runs trial division on a bit-serial restoring
//   divider: per divisor one square check, then 31 shift steps; divisors
//   from 2 while d*d <= value. Negatives, 0 and 1 skip the division and go
//   straight to the emit step.
// Reset:
//   counts return to 1, mode to all, row/column position to zero, result
//   channel empty.
// Stall:
//   the result register holds while result.ready is low; the next element
//   is taken and processed meanwhile and, if it gives a result, waits in the emit step.
// ----------------------------------------------------------------------------
module matrix_element_selector_prime
  import mes_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  mes_in_if.sink               elem,
  mes_out_if.source            result
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CHECK = 4'b0010,
    S_DIV   = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t state;

  logic [CFG_W-1:0] row_count;
  logic [CFG_W-1:0] col_count;
  mode_t            select_mode;

  logic [IDX_W-1:0] row_index;
  logic [IDX_W-1:0] col_index;

  // held element and its position flags
  logic signed [DATA_W-1:0] value;
  logic                     sel;
  logic                     last_col_r;
  logic                     last_row_r;

  // trial division datapath
  logic [DIV_W-1:0]     divisor;
  logic [SQ_W-1:0]      sq;
  logic [DIV_W-1:0]     rem;
  logic [U_W-1:0]       shreg;
  logic [BIT_CNT_W-1:0] bit_cnt;

  logic [IDX_W-1:0] last_row_idx;
  logic [IDX_W-1:0] last_col_idx;
  logic             last_col;
  logic             last_row;
  logic             border_sel;
  logic             diag_sel;
  logic [IDX_W:0]   idx_sum;
  logic [DIV_W:0]   rem_sh;
  logic [DIV_W-1:0] rem_next;
  logic [U_W-1:0]   mag;
  logic             accept;
  logic             need_result;
  logic             out_free;

  assign last_row_idx = last_index(row_count);
  assign last_col_idx = last_index(col_count);
  assign last_col     = col_index >= last_col_idx;
  assign last_row     = row_index >= last_row_idx;
  assign border_sel   = (row_index == '0) || last_row || (col_index == '0) || last_col;
  assign idx_sum      = {1'b0, row_index} + {1'b0, col_index};
  assign diag_sel     = (row_index == col_index) || (idx_sum == {1'b0, last_col_idx});

  assign mag          = value[U_W-1:0];
  assign rem_sh       = {rem, shreg[U_W-1]};
  assign rem_next     = (rem_sh >= {1'b0, divisor}) ? DIV_W'(rem_sh - {1'b0, divisor})
                                                    : rem_sh[DIV_W-1:0];

  assign elem.ready   = (state == S_IDLE);
  assign accept       = elem.valid && elem.ready;
  assign need_result  = sel || last_col_r;
  assign out_free     = !result.valid || result.ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count   <= CFG_W'(1);
      col_count   <= CFG_W'(1);
      select_mode <= MODE_ALL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROW_COUNT:   row_count   <= cfg_data;
        REG_COL_COUNT:   col_count   <= cfg_data;
        REG_SELECT_MODE: select_mode <= mode_t'(cfg_data[1:0]);
        default: ;
      endcase
    end
  end

  // position counters advance on every accepted element
  always_ff @(posedge clk) begin
    if (rst) begin
      row_index <= '0;
      col_index <= '0;
    end else if (accept) begin
      if (last_col) begin
        col_index <= '0;
        row_index <= last_row ? '0 : IDX_W'(row_index + IDX_W'(1));
      end else begin
        col_index <= IDX_W'(col_index + IDX_W'(1));
      end
    end
  end

  // sequencer and trial division
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      divisor <= DIV_W'(2);
      rem     <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            value      <= elem.element_value;
            last_col_r <= last_col;
            last_row_r <= last_row;
            case (select_mode)
              MODE_ALL:      sel <= 1'b1;
              MODE_BORDER:   sel <= border_sel;
              MODE_DIAGONAL: sel <= diag_sel;
              default:       sel <= 1'b0;
            endcase
            if (select_mode == MODE_PRIME && !elem.element_value[DATA_W-1] &&
                elem.element_value[U_W-1:1] != '0) begin
              divisor <= DIV_W'(2);
              sq      <= SQ_W'(4);
              state   <= S_CHECK;
            end else begin
              state <= S_EMIT;
            end
          end
        end
        S_CHECK: begin
          if (sq > SQ_W'(mag)) begin
            // no divisor up to the square root: prime
            sel   <= 1'b1;
            state <= S_EMIT;
          end else begin
            shreg   <= mag;
            rem     <= '0;
            bit_cnt <= '0;
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          rem     <= rem_next;
          shreg   <= {shreg[U_W-2:0], 1'b0};
          bit_cnt <= BIT_CNT_W'(bit_cnt + BIT_CNT_W'(1));
          if (bit_cnt == BIT_CNT_W'(U_W - 1)) begin
            if (rem_next == '0) begin
              state <= S_EMIT;
            end else begin
              // (d+1)^2 = d^2 + 2d + 1
              sq      <= SQ_W'(sq + SQ_W'({divisor, 1'b0}) + SQ_W'(1));
              divisor <= DIV_W'(divisor + DIV_W'(1));
              state   <= S_CHECK;
            end
          end
        end
        S_EMIT: begin
          if (!need_result || out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (state == S_EMIT && need_result && out_free) begin
      result.valid         <= 1'b1;
      result.out_value     <= sel ? value : '0;
      result.value_present <= sel;
      result.row_end       <= last_col_r;
      result.matrix_end    <= last_col_r && last_row_r;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  // divisor square tracks the divisor
  a_sq_track : assert property (@(posedge clk) disable iff (rst)
    state == S_CHECK |-> sq == SQ_W'(SQ_W'(divisor) * SQ_W'(divisor)))
    else $error("divisor square out of step with divisor");

  // a division only runs while d*d <= value
  a_div_bound : assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> sq <= SQ_W'(mag))
    else $error("trial division past the square root");

  // partial remainder stays below the divisor
  a_rem_range : assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> rem < divisor)
    else $error("partial remainder not reduced");

  // a new result only comes from the emit step
  a_emit_src : assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(state == S_EMIT))
    else $error("result raised outside emit step");

  // matrix end is only flagged on a row end
  a_mend_row : assert property (@(posedge clk) disable iff (rst)
    result.valid && result.matrix_end |-> result.row_end)
    else $error("matrix end without row end");

endmodule
